### src/spt_pkg.sv
// Shared types and constants for the sparse polynomial term table.
// Holds operation and status codes, the sequencer state type and the
// multiplier control group. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

  localparam int MAX_TERMS_DEF    = 16;
  localparam int MAX_EXPONENT_DEF = 63;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_EVALUATE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_MOVE,
    S_DEL_READ,
    S_DEL_CAPTURE,
    S_DEL_SHIFT,
    S_DEL_MOVE,
    S_EV_FETCH,
    S_EV_LOAD,
    S_EV_MUL,
    S_DONE
  } spt_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } spt_mul_ctl_t;

endpackage

`default_nettype wire

### src/spt_term_mem.sv
// Term store: one write port and one registered read port holding the
// coefficient and exponent of each term. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module spt_term_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int EXP_W = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [31:0]      wr_coef,
  input  wire logic [EXP_W-1:0] wr_exp,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [31:0]      rd_coef,
  output logic      [EXP_W-1:0] rd_exp
);

  logic [31:0]      coef_mem [DEPTH];
  logic [EXP_W-1:0] exp_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[wr_addr] <= wr_coef;
      exp_mem[wr_addr]  <= wr_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_coef <= coef_mem[rd_addr];
      rd_exp  <= exp_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/spt_mul.sv
// Shared multiplier holding the running power product of one term.
// Each step multiplies the product by the factor, keeping the low 32 bits.
// Depends on spt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spt_mul
  import spt_pkg::*;
(
  input  wire logic         clk,
  input  wire spt_mul_ctl_t ctl,
  input  wire logic [31:0]  load_val,
  input  wire logic [31:0]  factor,
  output logic      [31:0]  prod
);

  // Only the low 32 bits of the product are ever kept.
  logic [31:0] full;

  assign full = prod * factor;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= load_val;
    end else if (ctl.step) begin
      prod <= full;
    end
  end

endmodule

`default_nettype wire

### src/sparse_polynomial_term_table.sv
// Sparse polynomial term table: an ordered table of up to MAX_TERMS terms
// (coefficient and exponent) that accepts insert, delete and evaluate
// transactions and returns one result transaction for each.
// Input channel: in_valid/in_stall with operation, position, coefficient,
// exponent and point. Output channel: out_valid/out_stall with value and
// status. in_stall is high while a transaction is being worked on.
// Insert moves each term at or after the position up one slot, last first,
// then writes the new term; delete returns the coefficient of the removed
// term and moves each later term down one slot; evaluate adds up, for every
// term, its coefficient times the point raised to its exponent. Errors and
// the unused operation code go straight to the result. The single memory
// port pair moves one term at a time, read then write, and the single
// multiplier performs one power step a cycle. The result then sits in the
// output register until it is taken; the next transaction is accepted
// while it waits, but a further result waits in the sequencer while the
// output receiver stalls. Reset empties the table and drops any pending
// result; the term store itself is not cleared. Depends on spt_pkg,
// spt_term_mem and spt_mul.
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_term_table
  import spt_pkg::*;
#(
  parameter int MAX_TERMS    = MAX_TERMS_DEF,
  parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [4:0]         position,
  input  wire logic signed [31:0] coefficient,
  input  wire logic [5:0]         exponent,
  input  wire logic signed [31:0] point,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      value,
  output logic [1:0]              status
);

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int EXP_W = $clog2(MAX_EXPONENT + 1);

  spt_state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] slot;
  logic [31:0]      coef_r;
  logic [EXP_W-1:0] exp_r;
  logic [31:0]      point_r;
  logic [31:0]      acc;
  logic [EXP_W-1:0] ecnt;
  logic [31:0]      res_value;
  logic [1:0]       res_status;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_coef;
  logic [EXP_W-1:0] wr_exp;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_coef;
  logic [EXP_W-1:0] rd_exp;

  spt_mul_ctl_t     mul_ctl;
  logic [31:0]      prod;

  logic [9:0]       pos_w;
  logic [9:0]       cnt_w;
  logic             ins_ok;
  logic             del_empty;
  logic             del_bad;
  logic [CNT_W-1:0] slot_in;
  logic [8:0]       exp_wide;
  logic [8:0]       exp_sat;
  logic             accept;
  logic             ins_more;
  logic             del_more;
  logic             ev_more;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  assign pos_w     = 10'(position);
  assign cnt_w     = 10'(count);
  assign ins_ok    = (cnt_w < 10'(MAX_TERMS)) && (pos_w != 10'd0) &&
                     (pos_w <= cnt_w + 10'd1);
  assign del_empty = (count == '0);
  assign del_bad   = (pos_w == 10'd0) || (pos_w > cnt_w);
  assign slot_in   = CNT_W'(pos_w - 10'd1);
  assign exp_wide  = 9'(exponent);
  assign exp_sat   = (exp_wide > 9'(MAX_EXPONENT)) ? 9'(MAX_EXPONENT) : exp_wide;

  assign ins_more = (k > slot);
  assign del_more = (({1'b0, k} + 1'b1) < {1'b0, count});
  assign ev_more  = (k < count);
  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (operation)
            OP_INSERT:   state_next = ins_ok ? S_INS_SHIFT : S_DONE;
            OP_DELETE:   state_next = (del_empty || del_bad) ? S_DONE : S_DEL_READ;
            OP_EVALUATE: state_next = S_EV_FETCH;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_INS_SHIFT:   state_next = ins_more ? S_INS_MOVE : S_DONE;
      S_INS_MOVE:    state_next = S_INS_SHIFT;
      S_DEL_READ:    state_next = S_DEL_CAPTURE;
      S_DEL_CAPTURE: state_next = S_DEL_SHIFT;
      S_DEL_SHIFT:   state_next = del_more ? S_DEL_MOVE : S_DONE;
      S_DEL_MOVE:    state_next = S_DEL_SHIFT;
      S_EV_FETCH:    state_next = ev_more ? S_EV_LOAD : S_DONE;
      S_EV_LOAD:     state_next = S_EV_MUL;
      S_EV_MUL:      state_next = (ecnt == '0) ? S_EV_FETCH : S_EV_MUL;
      S_DONE:        state_next = out_free ? S_IDLE : S_DONE;
      default:       state_next = S_IDLE;
    endcase
  end

  // Memory and multiplier controls
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IDX_W'(k);
    wr_coef = rd_coef;
    wr_exp  = rd_exp;
    rd_en   = 1'b0;
    rd_addr = IDX_W'(k);
    mul_ctl = '0;
    case (state)
      S_INS_SHIFT: begin
        if (ins_more) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(k - 1'b1);
        end else begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(slot);
          wr_coef = coef_r;
          wr_exp  = exp_r;
        end
      end
      S_INS_MOVE: wr_en = 1'b1;
      S_DEL_READ: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(slot);
      end
      S_DEL_SHIFT: begin
        if (del_more) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(k + 1'b1);
        end
      end
      S_DEL_MOVE: wr_en = 1'b1;
      S_EV_FETCH: rd_en = ev_more;
      S_EV_LOAD:  mul_ctl.load = 1'b1;
      S_EV_MUL:   mul_ctl.step = (ecnt != '0);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_INS_SHIFT && !ins_more) begin
        count <= count + 1'b1;
      end
      if (state == S_DEL_SHIFT && !del_more) begin
        count <= count - 1'b1;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      value  <= res_value;
      status <= res_status;
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          coef_r     <= coefficient;
          exp_r      <= EXP_W'(exp_sat);
          point_r    <= point;
          slot       <= slot_in;
          acc        <= '0;
          res_value  <= '0;
          res_status <= ST_OK;
          case (operation)
            OP_INSERT: begin
              k <= count;
              if (!ins_ok) begin
                res_status <= ST_BAD;
              end
            end
            OP_DELETE: begin
              k <= slot_in;
              if (del_empty) begin
                res_status <= ST_EMPTY;
              end else if (del_bad) begin
                res_status <= ST_BAD;
              end
            end
            default: k <= '0;
          endcase
        end
      end
      S_INS_MOVE:    k <= k - 1'b1;
      S_DEL_CAPTURE: res_value <= rd_coef;
      S_DEL_MOVE:    k <= k + 1'b1;
      S_EV_FETCH: begin
        if (!ev_more) begin
          res_value <= acc;
        end
      end
      S_EV_LOAD: ecnt <= rd_exp;
      S_EV_MUL: begin
        if (ecnt == '0) begin
          acc <= acc + prod;
          k   <= k + 1'b1;
        end else begin
          ecnt <= ecnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  spt_term_mem #(
    .DEPTH (MAX_TERMS),
    .IDX_W (IDX_W),
    .EXP_W (EXP_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_coef (wr_coef),
    .wr_exp  (wr_exp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_coef (rd_coef),
    .rd_exp  (rd_exp)
  );

  spt_mul u_mul (
    .clk      (clk),
    .ctl      (mul_ctl),
    .load_val (rd_coef),
    .factor   (point_r),
    .prod     (prod)
  );

endmodule

`default_nettype wire
